// ===== rtl/pim_hello_option_parser_core_macros.svh =====
// Assertion macros for the hello option parser RTL.
`ifndef PIM_HELLO_OPTION_PARSER_CORE_MACROS_SVH
`define PIM_HELLO_OPTION_PARSER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define PIMHOP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define PIMHOP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define PIMHOP_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PIMHOP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/pimhop_pkg.sv =====
// Types, option codes and kind decode for the hello option parser.
package pimhop_pkg;

    // Header geometry and required value lengths
    localparam logic [15:0] HDR_LAST_IDX = 16'd3;
    localparam logic [15:0] SHORT_LEN    = 16'd2;
    localparam logic [15:0] WORD_LEN     = 16'd4;

    // Known option types
    localparam logic [15:0] OPT_HOLDTIME      = 16'd1;
    localparam logic [15:0] OPT_LAN_PRUNE     = 16'd2;
    localparam logic [15:0] OPT_DR_PRIORITY   = 16'd19;
    localparam logic [15:0] OPT_GENERATION_ID = 16'd20;
    localparam logic [15:0] OPT_STATE_REFRESH = 16'd21;

    // Reported kind codes
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_HOLDTIME      = 3'd0;
    localparam t_kind KIND_LAN_PRUNE     = 3'd1;
    localparam t_kind KIND_DR_PRIORITY   = 3'd2;
    localparam t_kind KIND_GENERATION_ID = 3'd3;
    localparam t_kind KIND_STATE_REFRESH = 3'd4;
    localparam t_kind KIND_OTHER         = 3'd5;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_VALUE  = 3'b010,
        PH_SKIP   = 3'b100
    } t_phase;

    // One result beat
    typedef struct packed {
        logic [15:0] opt_code;
        logic [15:0] option_length;
        t_kind       kind;
        logic [15:0] holdtime;
        logic [15:0] propag_dly;
        logic [15:0] ovr_interval;
        logic [31:0] value_word;
        logic [7:0]  refresh_version;
        logic [7:0]  refresh_interval;
        logic        has_option;
        logic        message_end;
        logic        malformed;
    } t_result;

    function automatic t_kind kind_of(input logic [15:0] opt_type);
        t_kind k;
        case (opt_type)
            OPT_HOLDTIME:      k = KIND_HOLDTIME;
            OPT_LAN_PRUNE:     k = KIND_LAN_PRUNE;
            OPT_DR_PRIORITY:   k = KIND_DR_PRIORITY;
            OPT_GENERATION_ID: k = KIND_GENERATION_ID;
            OPT_STATE_REFRESH: k = KIND_STATE_REFRESH;
            default:           k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/pimhop_parse.sv =====
// Option header and value parser: state registers plus per-byte decode.
`include "pim_hello_option_parser_core_macros.svh"

module pimhop_parse import pimhop_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase,   n_phase;
    logic [15:0] r_count,   n_count;
    logic [15:0] r_type,    n_type;
    logic [15:0] r_len,     n_len;
    logic [31:0] r_shift,   n_shift;
    logic        r_stopped, n_stopped;
    logic        r_bad,     n_bad;

    logic [15:0] count_inc;
    logic [15:0] need_len;
    logic        has;
    t_kind       hdr_kind;
    t_kind       k;
    t_result     res;

    assign count_inc = r_count + 16'd1;

    // Advance the parser by one byte
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_type    = r_type;
        n_len     = r_len;
        n_shift   = r_shift;
        n_stopped = r_stopped;
        n_bad     = r_bad;
        has       = 1'b0;
        k         = KIND_OTHER;
        hdr_kind  = KIND_OTHER;
        need_len  = WORD_LEN;
        if (!r_stopped) begin
            case (r_phase)
                PH_VALUE: begin
                    n_shift = {r_shift[23:0], i_data_byte};
                    n_count = count_inc;
                    if (count_inc == r_len) begin
                        has     = 1'b1;
                        k       = kind_of(r_type);
                        n_phase = PH_HEADER;
                        n_count = '0;
                    end
                end
                PH_SKIP: begin
                    n_count = count_inc;
                    if (count_inc == r_len) begin
                        n_phase = PH_HEADER;
                        n_count = '0;
                    end
                end
                default: begin
                    // Collect the big-endian type and length
                    case (r_count[1:0])
                        2'd0:    n_type = {i_data_byte, 8'h00};
                        2'd1:    n_type = r_type | {8'h00, i_data_byte};
                        2'd2:    n_len  = {i_data_byte, 8'h00};
                        default: n_len  = r_len | {8'h00, i_data_byte};
                    endcase
                    if (r_count < HDR_LAST_IDX) begin
                        n_count = count_inc;
                    end else begin
                        n_count  = '0;
                        n_phase  = PH_HEADER;
                        hdr_kind = kind_of(n_type);
                        need_len = (hdr_kind == KIND_HOLDTIME) ? SHORT_LEN : WORD_LEN;
                        if (hdr_kind == KIND_OTHER) begin
                            // Report unknown options now, skip their value
                            has = 1'b1;
                            k   = KIND_OTHER;
                            if (n_len != 16'd0) begin
                                n_phase = PH_SKIP;
                            end
                        end else if (n_len != need_len) begin
                            n_stopped = 1'b1;
                            n_bad     = 1'b1;
                        end else begin
                            n_phase = PH_VALUE;
                            n_shift = '0;
                        end
                    end
                end
            endcase
        end
    end

    // Build the result beat from the updated state
    always_comb begin
        res             = '0;
        res.kind        = KIND_OTHER;
        if (has) begin
            res.opt_code      = n_type;
            res.option_length = n_len;
            res.kind          = k;
            res.has_option    = 1'b1;
            case (k)
                KIND_HOLDTIME: res.holdtime = n_shift[15:0];
                KIND_LAN_PRUNE: begin
                    res.propag_dly   = n_shift[31:16];
                    res.ovr_interval = n_shift[15:0];
                end
                KIND_DR_PRIORITY, KIND_GENERATION_ID: res.value_word = n_shift;
                KIND_STATE_REFRESH: begin
                    res.refresh_version  = n_shift[31:24];
                    res.refresh_interval = n_shift[23:16];
                end
                default: ;
            endcase
        end
        if (i_last_byte) begin
            res.message_end = 1'b1;
            res.malformed   = n_bad || (!n_stopped && (n_phase == PH_VALUE));
        end
    end

    assign o_res_valid = i_take && (has || i_last_byte);
    assign o_res       = res;

    // Hold state between beats; drop back to idle after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_count   <= '0;
            r_type    <= '0;
            r_len     <= '0;
            r_shift   <= '0;
            r_stopped <= 1'b0;
            r_bad     <= 1'b0;
        end else if (i_take) begin
            if (i_last_byte) begin
                r_phase   <= PH_HEADER;
                r_count   <= '0;
                r_type    <= '0;
                r_len     <= '0;
                r_shift   <= '0;
                r_stopped <= 1'b0;
                r_bad     <= 1'b0;
            end else begin
                r_phase   <= n_phase;
                r_count   <= n_count;
                r_type    <= n_type;
                r_len     <= n_len;
                r_shift   <= n_shift;
                r_stopped <= n_stopped;
                r_bad     <= n_bad;
            end
        end
    end

    `PIMHOP_ASSERT_IMPL(a_phase_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_phase))
    `PIMHOP_ASSERT_IMPL(a_stop_marks_bad, i_clk, i_rst_n, r_stopped, r_bad)
    `PIMHOP_ASSERT_IMPL(a_hdr_count, i_clk, i_rst_n, r_phase == PH_HEADER, r_count <= HDR_LAST_IDX)
    `PIMHOP_ASSERT_IMPL(a_malformed_at_end, i_clk, i_rst_n, o_res_valid && o_res.malformed, o_res.message_end)
    `PIMHOP_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_take && i_last_byte, (r_phase == PH_HEADER) && (r_count == 16'd0) && !r_stopped && !r_bad)

endmodule

// ===== rtl/pimhop_out_reg.sv =====
// Result register with valid/ready handshake toward the consumer.
module pimhop_out_reg import pimhop_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_can_take
);

    logic    r_valid;
    t_result r_res;

    // Accept a new beat when empty or when the held beat leaves this cycle
    assign o_can_take = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload on load
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/pim_hello_option_parser_core.sv =====
// Top level of the PIM Hello option parser.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one message body byte per beat
//   on i_data_byte, with i_last_byte set on the final byte of a message.
//   Output channel (o_valid / i_ready) carries one result beat per completed
//   option record, per final byte, or one beat covering both.
//   Bytes that neither finish a record nor end the message give no beat.
// Timing:
//   A result is presented on o_valid the cycle after its byte is accepted.
//   One byte is accepted per cycle while o_ready is high; the single result
//   register is the only storage on the output side.
// Reset:
//   Synchronous active-low reset returns the parser to the header phase with
//   no pending result. The parser also returns to that state after each
//   final byte, ready for the next message.
// Stall:
//   While a result waits and i_ready is low, o_ready drops and input stops.
module pim_hello_option_parser_core import pimhop_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_opt_code,
    output logic [15:0] o_option_length,
    output logic [2:0]  o_kind,
    output logic [15:0] o_holdtime,
    output logic [15:0] o_propag_dly,
    output logic [15:0] o_ovr_interval,
    output logic [31:0] o_value_word,
    output logic [7:0]  o_refresh_version,
    output logic [7:0]  o_refresh_interval,
    output logic        o_has_option,
    output logic        o_message_end,
    output logic        o_malformed
);

    logic    take;
    logic    can_take;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign o_ready = can_take;
    assign take    = i_valid && can_take;

    pimhop_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    pimhop_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_res      (out_res),
        .o_can_take (can_take)
    );

    // Unpack the result beat onto the ports
    assign o_opt_code          = out_res.opt_code;
    assign o_option_length     = out_res.option_length;
    assign o_kind              = out_res.kind;
    assign o_holdtime          = out_res.holdtime;
    assign o_propag_dly        = out_res.propag_dly;
    assign o_ovr_interval      = out_res.ovr_interval;
    assign o_value_word        = out_res.value_word;
    assign o_refresh_version   = out_res.refresh_version;
    assign o_refresh_interval  = out_res.refresh_interval;
    assign o_has_option        = out_res.has_option;
    assign o_message_end       = out_res.message_end;
    assign o_malformed         = out_res.malformed;

endmodule

// ===== dv/pim_hello_option_parser_checker.sv =====
// Checker for the hello option parser: predicts result beats from input beats and compares.
module pim_hello_option_parser_checker import pimhop_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [15:0] o_opt_code,
    input  logic [15:0] o_option_length,
    input  logic [2:0]  o_kind,
    input  logic [15:0] o_holdtime,
    input  logic [15:0] o_propag_dly,
    input  logic [15:0] o_ovr_interval,
    input  logic [31:0] o_value_word,
    input  logic [7:0]  o_refresh_version,
    input  logic [7:0]  o_refresh_interval,
    input  logic        o_has_option,
    input  logic        o_message_end,
    input  logic        o_malformed,
    output int          o_fail_count,
    output int          o_pending
);

    // Parser state as seen from outside
    t_phase      parse_phase;
    logic [15:0] parse_count;
    logic [15:0] parse_type;
    logic [15:0] parse_length;
    logic [31:0] parse_shift;
    logic        parse_stopped;
    logic        parse_bad;

    t_result     parsed_beats[$];
    t_result     next_beat;
    t_result     seen_beat;
    t_result     want_beat;
    bit          beat_due;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Map an option type to its reported kind
    function automatic t_kind option_kind(input logic [15:0] opt_type);
        case (opt_type)
            OPT_HOLDTIME:      return KIND_HOLDTIME;
            OPT_LAN_PRUNE:     return KIND_LAN_PRUNE;
            OPT_DR_PRIORITY:   return KIND_DR_PRIORITY;
            OPT_GENERATION_ID: return KIND_GENERATION_ID;
            OPT_STATE_REFRESH: return KIND_STATE_REFRESH;
            default:           return KIND_OTHER;
        endcase
    endfunction

    task automatic clear_parse();
        parse_phase   = PH_HEADER;
        parse_count   = '0;
        parse_type    = '0;
        parse_length  = '0;
        parse_shift   = '0;
        parse_stopped = 1'b0;
        parse_bad     = 1'b0;
    endtask

    // Advance the parser by one byte and form the beat it causes, if any
    task automatic parse_byte(input logic [7:0] d, input logic last,
                              output bit emit, output t_result r);
        t_kind       k;
        logic [15:0] need;
        bit          rec;
        rec = 1'b0;
        k   = KIND_OTHER;
        r   = '0;
        if (!parse_stopped) begin
            if (parse_phase == PH_VALUE) begin
                parse_shift = {parse_shift[23:0], d};
                parse_count = parse_count + 16'd1;
                if (parse_count == parse_length) begin
                    rec         = 1'b1;
                    k           = option_kind(parse_type);
                    parse_phase = PH_HEADER;
                    parse_count = '0;
                end
            end else if (parse_phase == PH_SKIP) begin
                parse_count = parse_count + 16'd1;
                if (parse_count == parse_length) begin
                    parse_phase = PH_HEADER;
                    parse_count = '0;
                end
            end else begin
                case (parse_count[1:0])
                    2'd0:    parse_type   = {d, 8'h00};
                    2'd1:    parse_type[7:0] = d;
                    2'd2:    parse_length = {d, 8'h00};
                    default: parse_length[7:0] = d;
                endcase
                if (parse_count < HDR_LAST_IDX) begin
                    parse_count = parse_count + 16'd1;
                end else begin
                    parse_count = '0;
                    parse_phase = PH_HEADER;
                    k = option_kind(parse_type);
                    if (k == KIND_OTHER) begin
                        // Report unknown options at the header, then skip the value
                        rec = 1'b1;
                        if (parse_length != 16'd0) parse_phase = PH_SKIP;
                    end else begin
                        need = (k == KIND_HOLDTIME) ? SHORT_LEN : WORD_LEN;
                        if (parse_length != need) begin
                            parse_stopped = 1'b1;
                            parse_bad     = 1'b1;
                        end else begin
                            parse_phase = PH_VALUE;
                            parse_shift = '0;
                        end
                    end
                end
            end
        end

        emit = rec || last;
        r.kind = KIND_OTHER;
        if (rec) begin
            r.opt_code      = parse_type;
            r.option_length = parse_length;
            r.kind          = k;
            r.has_option    = 1'b1;
            case (k)
                KIND_HOLDTIME: r.holdtime = parse_shift[15:0];
                KIND_LAN_PRUNE: begin
                    r.propag_dly   = parse_shift[31:16];
                    r.ovr_interval = parse_shift[15:0];
                end
                KIND_DR_PRIORITY, KIND_GENERATION_ID: r.value_word = parse_shift;
                KIND_STATE_REFRESH: begin
                    r.refresh_version  = parse_shift[31:24];
                    r.refresh_interval = parse_shift[23:16];
                end
                default: ;
            endcase
        end
        if (last) begin
            r.message_end = 1'b1;
            r.malformed   = parse_bad || (!parse_stopped && parse_phase == PH_VALUE);
            clear_parse();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $time, name, exp_v, act_v);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    // Compare result beats, then predict from the input beat of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            parsed_beats.delete();
        end else begin
            if (o_valid && i_ready) begin
                seen_beat.opt_code          = o_opt_code;
                seen_beat.option_length     = o_option_length;
                seen_beat.kind              = o_kind;
                seen_beat.holdtime          = o_holdtime;
                seen_beat.propag_dly        = o_propag_dly;
                seen_beat.ovr_interval      = o_ovr_interval;
                seen_beat.value_word        = o_value_word;
                seen_beat.refresh_version   = o_refresh_version;
                seen_beat.refresh_interval  = o_refresh_interval;
                seen_beat.has_option        = o_has_option;
                seen_beat.message_end       = o_message_end;
                seen_beat.malformed         = o_malformed;
                if (parsed_beats.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual %0h",
                             $time, seen_beat);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want_beat = parsed_beats.pop_front();
                    check_field("opt_code", 32'(want_beat.opt_code),
                                32'(seen_beat.opt_code));
                    check_field("option_length", 32'(want_beat.option_length),
                                32'(seen_beat.option_length));
                    check_field("kind", 32'(want_beat.kind), 32'(seen_beat.kind));
                    check_field("holdtime", 32'(want_beat.holdtime),
                                32'(seen_beat.holdtime));
                    check_field("propag_dly", 32'(want_beat.propag_dly),
                                32'(seen_beat.propag_dly));
                    check_field("ovr_interval", 32'(want_beat.ovr_interval),
                                32'(seen_beat.ovr_interval));
                    check_field("value_word", want_beat.value_word, seen_beat.value_word);
                    check_field("refresh_version", 32'(want_beat.refresh_version),
                                32'(seen_beat.refresh_version));
                    check_field("refresh_interval", 32'(want_beat.refresh_interval),
                                32'(seen_beat.refresh_interval));
                    check_field("has_option", 32'(want_beat.has_option),
                                32'(seen_beat.has_option));
                    check_field("message_end", 32'(want_beat.message_end),
                                32'(seen_beat.message_end));
                    check_field("malformed", 32'(want_beat.malformed),
                                32'(seen_beat.malformed));
                end
            end
            if (i_valid && o_ready) begin
                parse_byte(i_data_byte, i_last_byte, beat_due, next_beat);
                if (beat_due) parsed_beats.push_back(next_beat);
            end
        end
        o_pending = parsed_beats.size();
    end

endmodule

// ===== dv/tb_pim_hello_option_parser_core.sv =====
// Testbench top for the hello option parser: clock, reset, message stimulus and verdict.
module tb_pim_hello_option_parser_core;
    import pimhop_pkg::*;

    localparam int RANDOM_BYTES = 1700;
    localparam int PHASE_COUNT  = 4;
    localparam logic [15:0] OPT_ADDR_LIST = 16'd24;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [7:0]  i_data_byte  = 8'h00;
    logic        i_last_byte  = 1'b0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [15:0] o_opt_code;
    logic [15:0] o_option_length;
    logic [2:0]  o_kind;
    logic [15:0] o_holdtime;
    logic [15:0] o_propag_dly;
    logic [15:0] o_ovr_interval;
    logic [31:0] o_value_word;
    logic [7:0]  o_refresh_version;
    logic [7:0]  o_refresh_interval;
    logic        o_has_option;
    logic        o_message_end;
    logic        o_malformed;
    int          fail_count;
    int          beats_pending;

    int          idle_pct  = 0;
    int          stall_pct = 0;
    logic [7:0]  msg_q[$];
    int          dead_bytes;
    int          bytes_sent;

    pim_hello_option_parser_core i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_opt_code          (o_opt_code),
        .o_option_length     (o_option_length),
        .o_kind              (o_kind),
        .o_holdtime          (o_holdtime),
        .o_propag_dly        (o_propag_dly),
        .o_ovr_interval      (o_ovr_interval),
        .o_value_word        (o_value_word),
        .o_refresh_version   (o_refresh_version),
        .o_refresh_interval  (o_refresh_interval),
        .o_has_option        (o_has_option),
        .o_message_end       (o_message_end),
        .o_malformed         (o_malformed)
    );

    pim_hello_option_parser_checker i_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_opt_code          (o_opt_code),
        .o_option_length     (o_option_length),
        .o_kind              (o_kind),
        .o_holdtime          (o_holdtime),
        .o_propag_dly        (o_propag_dly),
        .o_ovr_interval      (o_ovr_interval),
        .o_value_word        (o_value_word),
        .o_refresh_version   (o_refresh_version),
        .o_refresh_interval  (o_refresh_interval),
        .o_has_option        (o_has_option),
        .o_message_end       (o_message_end),
        .o_malformed         (o_malformed),
        .o_fail_count        (fail_count),
        .o_pending           (beats_pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Stall the result side at the current rate
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Stop a hung run
    initial begin
        #1000000;
        $display("pim_hello_option_parser_core regression: fail");
        $finish;
    end

    // Present one byte beat and hold it until accepted
    task automatic send_beat(input logic [7:0] d, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_message();
        int n;
        n = msg_q.size();
        for (int i = 0; i < n; i++) send_beat(msg_q[i], i == n - 1);
        bytes_sent = bytes_sent + n - dead_bytes;
        msg_q.delete();
        dead_bytes = 0;
    endtask

    task automatic push_header(input logic [15:0] opt_type, input logic [15:0] len);
        msg_q.push_back(opt_type[15:8]);
        msg_q.push_back(opt_type[7:0]);
        msg_q.push_back(len[15:8]);
        msg_q.push_back(len[7:0]);
    endtask

    task automatic push_noise(input int n);
        for (int i = 0; i < n; i++) msg_q.push_back(8'($urandom_range(255)));
    endtask

    function automatic logic [15:0] unknown_type();
        logic [15:0] t;
        t = 16'($urandom_range(65535));
        // Move known codes off their value
        if (t == OPT_HOLDTIME || t == OPT_LAN_PRUNE || t == OPT_DR_PRIORITY ||
            t == OPT_GENERATION_ID || t == OPT_STATE_REFRESH)
            t = t ^ 16'h0100;
        return t;
    endfunction

    function automatic logic [15:0] known_type(input int sel);
        case (sel)
            0:       return OPT_HOLDTIME;
            1:       return OPT_LAN_PRUNE;
            2:       return OPT_DR_PRIORITY;
            3:       return OPT_GENERATION_ID;
            default: return OPT_STATE_REFRESH;
        endcase
    endfunction

    // Build one random message: pure noise, or well-formed options then an optional broken tail
    task automatic build_message();
        int          nopt;
        int          pick;
        int          tail;
        int          cut;
        logic [15:0] t;
        logic [15:0] len;
        logic [15:0] need;
        if ($urandom_range(99) < 10) begin
            push_noise($urandom_range(1, 12));
        end else begin
            nopt = $urandom_range(0, 4);
            for (int i = 0; i < nopt; i++) begin
                pick = $urandom_range(0, 7);
                if (pick < 5) begin
                    t = known_type(pick);
                    need = (t == OPT_HOLDTIME) ? SHORT_LEN : WORD_LEN;
                    push_header(t, need);
                    push_noise(need);
                end else begin
                    t = (pick == 5) ? OPT_ADDR_LIST : unknown_type();
                    len = 16'($urandom_range(0, 16));
                    push_header(t, len);
                    push_noise(len);
                end
            end
            tail = $urandom_range(99);
            if (tail < 55) begin
                // clean end
            end else if (tail < 68) begin
                // header remnant
                push_noise($urandom_range(1, 3));
            end else if (tail < 80) begin
                // known option with a wrong length, then bytes after the stop
                t = known_type($urandom_range(0, 4));
                need = (t == OPT_HOLDTIME) ? SHORT_LEN : WORD_LEN;
                len = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                               : 16'($urandom_range(0, 8));
                if (len == need) len = len + 16'd1;
                push_header(t, len);
                dead_bytes = $urandom_range(0, 3);
                push_noise(dead_bytes);
            end else if (tail < 90) begin
                // known value cut off
                t = known_type($urandom_range(0, 4));
                need = (t == OPT_HOLDTIME) ? SHORT_LEN : WORD_LEN;
                push_header(t, need);
                cut = $urandom_range(0, need - 1);
                push_noise(cut);
            end else begin
                // skipped value cut off, often with a large length
                len = ($urandom_range(1) == 0) ? 16'($urandom_range(65535))
                                               : 16'($urandom_range(1, 20));
                if (len == 16'd0) len = 16'd1;
                push_header(unknown_type(), len);
                cut = $urandom_range(0, 6);
                if (cut >= len) cut = len - 1;
                push_noise(cut);
            end
        end
        if (msg_q.size() == 0) push_noise(1);
    endtask

    initial begin
        int phase_target;
        dead_bytes = 0;
        bytes_sent = 0;

        // Hold reset, then release at a falling edge
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Holdtime with all-ones value: record and message end in one beat
        push_header(OPT_HOLDTIME, SHORT_LEN);
        msg_q.push_back(8'hFF);
        msg_q.push_back(8'hFF);
        send_message();
        // Lone remnant byte
        msg_q.push_back(8'h00);
        send_message();
        // Unknown all-ones header, skipped value cut off
        push_header(16'hFFFF, 16'hFFFF);
        msg_q.push_back(8'h5A);
        send_message();
        // DR priority with a wrong length
        push_header(OPT_DR_PRIORITY, 16'd3);
        msg_q.push_back(8'hA5);
        dead_bytes = 1;
        send_message();
        // LAN prune cut off inside its value
        push_header(OPT_LAN_PRUNE, WORD_LEN);
        msg_q.push_back(8'h12);
        msg_q.push_back(8'h34);
        send_message();
        // Zero type with zero length ending the message
        push_header(16'h0000, 16'h0000);
        send_message();

        // Random messages over the idle and stall phases
        bytes_sent = 0;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            phase_target = RANDOM_BYTES * (ph + 1) / PHASE_COUNT;
            while (bytes_sent < phase_target) begin
                build_message();
                send_message();
            end
        end

        // Drain, then wait for stray beats
        i_valid <= 1'b0;
        while (beats_pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("pim_hello_option_parser_core regression: pass");
        else
            $display("pim_hello_option_parser_core regression: fail");
        $finish;
    end

endmodule
